/* rtl/core/i2cra_pkg.sv */
// ----------------------------------------------------------------------------
// I2C target register access package
// Shared types and codes for the banked register access front end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cra_pkg;

  localparam logic [2:0] REQ_ADDR_WR = 3'd0;
  localparam logic [2:0] REQ_ADDR_RD = 3'd1;
  localparam logic [2:0] REQ_DATA    = 3'd2;
  localparam logic [2:0] REQ_TX      = 3'd3;

  localparam logic [1:0] CFG_BANK_MASK    = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_BANK = 2'd1;
  localparam logic [1:0] CFG_EVENT_ENABLE = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_HIGH,
    PH_ADDR_LOW,
    PH_DATA_RX,
    PH_TX
  } phase_e;

  typedef enum logic [1:0] {
    RES_ACK,
    RES_NACK,
    RES_TX,
    RES_DONE
  } kind_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
    logic       store_accepts;
    logic [7:0] read_data;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  device_byte;
    logic [7:0]  address_high;
    logic [15:0] reg_ptr;
    logic [15:0] first_addr;
    logic [15:0] count;
    logic [5:0]  bank;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  bank_number;
    logic [9:0]  offset;
    logic        write_strobe;
    logic [7:0]  data_byte;
    logic [6:0]  device_address;
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic        is_write;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/i2cra_step.sv */
// ----------------------------------------------------------------------------
// I2C target register access step logic
// Next state and up to two results for one registered bus event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cra_step #(
  parameter int OFFSET_BITS = 10,
  parameter int BANK_BITS   = 6
) (
  input  i2cra_pkg::state_t st_i,
  input  i2cra_pkg::item_t  item_i,
  input  logic [63:0]       mask_i,
  input  logic              event_enable_i,
  output i2cra_pkg::state_t nxt_o,
  output i2cra_pkg::res_t   r0_o,
  output i2cra_pkg::res_t   r1_o,
  output logic              two_o
);
  import i2cra_pkg::*;

  localparam logic [15:0] OffMask  = 16'((32'd1 << OFFSET_BITS) - 32'd1);
  localparam logic [5:0]  BankMask = 6'((32'd1 << BANK_BITS) - 32'd1);

  logic        bank_ok;
  logic [9:0]  off;
  logic [15:0] ptr_adv;
  logic [15:0] cnt_adv;
  logic [15:0] ptr_new;
  logic [7:0]  tx_data;
  res_t        tx_res;
  res_t        open_res;
  state_t      open_st;
  res_t        done_res;
  res_t        main_res;
  logic        brk;
  logic        is_wr;

  assign bank_ok = mask_i[st_i.bank];
  assign off     = 10'(st_i.reg_ptr & OffMask);
  assign ptr_adv = (st_i.reg_ptr & ~OffMask) | ((st_i.reg_ptr + 16'd1) & OffMask);
  assign cnt_adv = (st_i.count == COUNT_MAX) ? st_i.count : st_i.count + 16'd1;
  assign ptr_new = {st_i.address_high, item_i.rx_byte};
  assign tx_data = bank_ok ? item_i.read_data : 8'd0;

  always_comb begin
    tx_res             = '0;
    tx_res.kind        = RES_TX;
    tx_res.bank_number = st_i.bank;
    tx_res.offset      = off;
    tx_res.data_byte   = tx_data;
  end

  always_comb begin
    open_st  = st_i;
    open_res = '0;
    if (item_i.req_type == REQ_ADDR_WR) begin
      open_st.device_byte = item_i.rx_byte;
      open_st.phase       = PH_ADDR_HIGH;
      open_res.kind       = RES_ACK;
    end else if (item_i.req_type == REQ_ADDR_RD) begin
      open_st.device_byte = item_i.rx_byte;
      open_st.first_addr  = st_i.reg_ptr;
      open_st.count       = 16'd1;
      open_st.reg_ptr     = ptr_adv;
      open_st.phase       = PH_TX;
      open_res            = tx_res;
    end else begin
      open_st.phase = PH_IDLE;
      open_res.kind = RES_NACK;
    end
  end

  always_comb begin
    done_res                = '0;
    done_res.kind           = RES_DONE;
    done_res.device_address = st_i.device_byte[7:1];
    done_res.start_address  = st_i.first_addr;
    done_res.byte_count     = st_i.count;
    done_res.is_write       = is_wr;
  end

  always_comb begin
    nxt_o    = open_st;
    main_res = open_res;
    brk      = 1'b0;
    is_wr    = 1'b0;
    unique case (st_i.phase)
      PH_ADDR_HIGH: begin
        if (item_i.req_type == REQ_DATA) begin
          nxt_o              = st_i;
          nxt_o.address_high = item_i.rx_byte;
          nxt_o.phase        = PH_ADDR_LOW;
          main_res           = '0;
          main_res.kind      = RES_ACK;
        end
      end
      PH_ADDR_LOW: begin
        if (item_i.req_type == REQ_DATA) begin
          nxt_o            = st_i;
          nxt_o.reg_ptr    = ptr_new;
          nxt_o.bank       = 6'(ptr_new >> OFFSET_BITS) & BankMask;
          nxt_o.first_addr = ptr_new;
          nxt_o.count      = 16'd0;
          nxt_o.phase      = PH_DATA_RX;
          main_res         = '0;
          main_res.kind    = RES_ACK;
        end
      end
      PH_DATA_RX: begin
        is_wr = 1'b1;
        if (item_i.req_type == REQ_DATA) begin
          nxt_o                 = st_i;
          nxt_o.reg_ptr         = ptr_adv;
          nxt_o.count           = cnt_adv;
          main_res              = '0;
          main_res.kind         = (bank_ok && item_i.store_accepts) ? RES_ACK : RES_NACK;
          main_res.bank_number  = st_i.bank;
          main_res.offset       = off;
          main_res.write_strobe = bank_ok && item_i.store_accepts;
          main_res.data_byte    = item_i.rx_byte;
        end else begin
          brk = 1'b1;
        end
      end
      PH_TX: begin
        if (item_i.req_type == REQ_TX) begin
          nxt_o         = st_i;
          nxt_o.reg_ptr = ptr_adv;
          nxt_o.count   = cnt_adv;
          main_res      = tx_res;
        end else begin
          brk = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    two_o = brk && event_enable_i;
    if (two_o) begin
      r0_o = done_res;
      r1_o = main_res;
    end else begin
      r0_o = main_res;
      r1_o = main_res;
    end
    r0_o.last = !two_o;
    r1_o.last = 1'b1;
  end

endmodule

`default_nettype wire

/* rtl/core/i2cra_out_stage.sv */
// ----------------------------------------------------------------------------
// I2C target register access output stage
// Result register with one spill entry for the second result of an event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cra_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            two_i,
  input  i2cra_pkg::res_t r0_i,
  input  i2cra_pkg::res_t r1_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output i2cra_pkg::res_t out_o,
  output logic            room_o
);
  import i2cra_pkg::*;

  logic out_valid_q;
  logic out_valid_d;
  logic spill_valid_q;
  logic spill_valid_d;
  res_t out_q;
  res_t out_d;
  res_t spill_q;
  res_t spill_d;
  logic pop;

  assign pop    = out_valid_q && out_ready_i;
  assign room_o = !spill_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d   = out_valid_q;
    spill_valid_d = spill_valid_q;
    out_d         = out_q;
    spill_d       = spill_q;
    if (load_i) begin
      out_valid_d   = 1'b1;
      out_d         = r0_i;
      spill_valid_d = two_i;
      spill_d       = r1_i;
    end else if (pop) begin
      if (spill_valid_q) begin
        out_d         = spill_q;
        spill_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spill_valid_q <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      spill_valid_q <= spill_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    spill_q <= spill_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* rtl/core/i2c_target_register_access_fsm_core.sv */
// ----------------------------------------------------------------------------
// I2C target register access core
// Turns I2C target bus events into register store accesses and replies.
// ----------------------------------------------------------------------------
// Each input transfer is one bus event (address byte, data byte, transmit
// request or other). Each event gives one or two output transfers: an ack,
// a nack or a transmit byte, preceded by a transaction done record when a
// write or read transaction is broken and event reporting is enabled.
// An accepted event is held in an input register, evaluated combinationally and
// its results are written into the output register once that has room, so the
// first result passes the input register and then the output register.
// With the output side ready and the spill entry empty, one event is taken every
// cycle; an event with a done record puts its second result into the single
// spill entry behind the output register, and no event moves on until it drains.
// When the receiver stalls, the output register and its spill entry hold and
// the input register stays full, so in_ready_o drops after one more event.
// Reset empties all stages and returns the transaction state to idle with
// no bank present, default bank zero and reporting off. Configuration writes
// take effect at once and are meant to happen while no event is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_register_access_fsm_core #(
  parameter int OFFSET_BITS = 10,
  parameter int BANK_BITS   = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        store_accepts_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [5:0]  bank_number_o,
  output logic [9:0]  offset_o,
  output logic        write_strobe_o,
  output logic [7:0]  data_byte_o,
  output logic [6:0]  device_address_o,
  output logic [15:0] start_address_o,
  output logic [15:0] byte_count_o,
  output logic        is_write_o,
  output logic        last_o
);
  import i2cra_pkg::*;

  logic        in_valid_q;
  item_t       in_q;
  state_t      state_q;
  state_t      state_nxt;
  logic [63:0] mask_q;
  logic        event_enable_q;
  res_t        r0;
  res_t        r1;
  res_t        out_res;
  logic        two;
  logic        room;
  logic        proceed;

  assign proceed    = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proceed) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= '{req_type: req_type_i, rx_byte: rx_byte_i,
                store_accepts: store_accepts_i, read_data: read_data_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q         <= '0;
      event_enable_q <= 1'b0;
      state_q        <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (proceed) begin
        state_q <= state_nxt;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_BANK_MASK:    mask_q         <= cfg_wdata_i;
          CFG_DEFAULT_BANK: state_q.bank   <= cfg_wdata_i[5:0];
          CFG_EVENT_ENABLE: event_enable_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  i2cra_step #(
    .OFFSET_BITS(OFFSET_BITS),
    .BANK_BITS  (BANK_BITS)
  ) u_step (
    .st_i          (state_q),
    .item_i        (in_q),
    .mask_i        (mask_q),
    .event_enable_i(event_enable_q),
    .nxt_o         (state_nxt),
    .r0_o          (r0),
    .r1_o          (r1),
    .two_o         (two)
  );

  i2cra_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proceed),
    .two_i      (two),
    .r0_i       (r0),
    .r1_i       (r1),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_res),
    .room_o     (room)
  );

  assign result_kind_o    = out_res.kind;
  assign bank_number_o    = out_res.bank_number;
  assign offset_o         = out_res.offset;
  assign write_strobe_o   = out_res.write_strobe;
  assign data_byte_o      = out_res.data_byte;
  assign device_address_o = out_res.device_address;
  assign start_address_o  = out_res.start_address;
  assign byte_count_o     = out_res.byte_count;
  assign is_write_o       = out_res.is_write;
  assign last_o           = out_res.last;

endmodule

`default_nettype wire

/* rtl/core/i2cra_checker.sv */
// ----------------------------------------------------------------------------
// I2C target register access checker
// Port level checks on the result stream of the access core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic        write_strobe_o,
  input logic [7:0]  data_byte_o,
  input logic [15:0] byte_count_o,
  input logic        last_o
);
  import i2cra_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(data_byte_o) && $stable(last_o))
    else $error("Stalled result transfer changed.");

  a_strobe_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_strobe_o |-> result_kind_o == RES_ACK)
    else $error("Write strobe on a result that is not an ack.");

  a_done_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_DONE |-> !last_o && data_byte_o == 8'd0)
    else $error("Done record ended an event or carried data.");

  a_count_done_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RES_DONE |-> byte_count_o == 16'd0)
    else $error("Byte count outside a done record.");

endmodule

bind i2c_target_register_access_fsm_core i2cra_checker u_i2cra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .write_strobe_o(write_strobe_o),
  .data_byte_o   (data_byte_o),
  .byte_count_o  (byte_count_o),
  .last_o        (last_o)
);

`default_nettype wire

/* bench/i2c_target_register_access_fsm_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target register access core testbench
// Feeds bus events into the core through a queued driver and checks every
// reply against a cycle-free model of the transaction state. The run goes
// through a short directed sequence, then random transactions under several
// bank masks, default banks and reporting modes, with idle gaps on both sides in four of six segments.
// ----------------------------------------------------------------------------

module i2c_target_register_access_fsm_core_tb;
  import i2cra_pkg::*;

  localparam logic [2:0] REQ_OTHER      = 3'd4;
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int unsigned SEGMENT_EVENTS   = 235;
  localparam int unsigned PRESSURE_CYCLES  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_BANK_MASK;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = REQ_ADDR_WR;
  logic [7:0]  rx_byte_i = '0;
  logic        store_accepts_i = 1'b0;
  logic [7:0]  read_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [5:0]  bank_number_o;
  logic [9:0]  offset_o;
  logic        write_strobe_o;
  logic [7:0]  data_byte_o;
  logic [6:0]  device_address_o;
  logic [15:0] start_address_o;
  logic [15:0] byte_count_o;
  logic        is_write_o;
  logic        last_o;

  i2c_target_register_access_fsm_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .rx_byte_i        (rx_byte_i),
    .store_accepts_i  (store_accepts_i),
    .read_data_i      (read_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .bank_number_o    (bank_number_o),
    .offset_o         (offset_o),
    .write_strobe_o   (write_strobe_o),
    .data_byte_o      (data_byte_o),
    .device_address_o (device_address_o),
    .start_address_o  (start_address_o),
    .byte_count_o     (byte_count_o),
    .is_write_o       (is_write_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  phase_e      txn_phase = PH_IDLE;
  logic [7:0]  dev_byte = '0;
  logic [7:0]  addr_high = '0;
  logic [15:0] reg_ptr = '0;
  logic [15:0] first_addr = '0;
  logic [15:0] xfer_count = '0;
  logic [5:0]  cur_bank = '0;
  logic [63:0] bank_mask = '0;
  logic        report_en = 1'b0;

  item_t       pending_events[$];
  item_t       offered_event;
  res_t        staged_replies[$];
  res_t        expected_replies[$];

  int unsigned events_issued = 0;
  int unsigned events_accepted = 0;
  int unsigned replies_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned settings_applied = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  function automatic void stage_reply(kind_e k, logic [5:0] bank, logic [9:0] off,
                                      logic ws, logic [7:0] data, logic [6:0] dev,
                                      logic [15:0] start, logic [15:0] cnt, logic isw);
    res_t r;
    r.kind           = k;
    r.bank_number    = bank;
    r.offset         = off;
    r.write_strobe   = ws;
    r.data_byte      = data;
    r.device_address = dev;
    r.start_address  = start;
    r.byte_count     = cnt;
    r.is_write       = isw;
    r.last           = 1'b0;
    staged_replies.push_back(r);
  endfunction

  function automatic void stage_plain(kind_e k);
    stage_reply(k, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0);
  endfunction

  function automatic void step_pointer();
    reg_ptr[9:0] = reg_ptr[9:0] + 10'd1;
    if (xfer_count != COUNT_MAX) xfer_count = xfer_count + 16'd1;
  endfunction

  function automatic void transmit_byte(logic [7:0] rd);
    stage_reply(RES_TX, cur_bank, reg_ptr[9:0], 1'b0, bank_mask[cur_bank] ? rd : 8'h00,
                '0, '0, '0, 1'b0);
    step_pointer();
  endfunction

  function automatic void report_done(logic isw);
    if (report_en) begin
      stage_reply(RES_DONE, '0, '0, 1'b0, '0, dev_byte[7:1], first_addr, xfer_count, isw);
    end
  endfunction

  function automatic void open_transaction(item_t ev);
    case (ev.req_type)
      REQ_ADDR_WR: begin
        dev_byte  = ev.rx_byte;
        txn_phase = PH_ADDR_HIGH;
        stage_plain(RES_ACK);
      end
      REQ_ADDR_RD: begin
        dev_byte   = ev.rx_byte;
        first_addr = reg_ptr;
        xfer_count = '0;
        txn_phase  = PH_TX;
        transmit_byte(ev.read_data);
      end
      default: begin
        txn_phase = PH_IDLE;
        stage_plain(RES_NACK);
      end
    endcase
  endfunction

  function automatic void predict_bus_event(item_t ev);
    staged_replies.delete();
    case (txn_phase)
      PH_ADDR_HIGH: begin
        if (ev.req_type == REQ_DATA) begin
          addr_high = ev.rx_byte;
          txn_phase = PH_ADDR_LOW;
          stage_plain(RES_ACK);
        end else begin
          open_transaction(ev);
        end
      end
      PH_ADDR_LOW: begin
        if (ev.req_type == REQ_DATA) begin
          reg_ptr    = {addr_high, ev.rx_byte};
          cur_bank   = reg_ptr[15:10];
          first_addr = reg_ptr;
          xfer_count = '0;
          txn_phase  = PH_DATA_RX;
          stage_plain(RES_ACK);
        end else begin
          open_transaction(ev);
        end
      end
      PH_DATA_RX: begin
        if (ev.req_type == REQ_DATA) begin
          if (bank_mask[cur_bank] && ev.store_accepts) begin
            stage_reply(RES_ACK, cur_bank, reg_ptr[9:0], 1'b1, ev.rx_byte, '0, '0, '0, 1'b0);
          end else begin
            stage_reply(RES_NACK, cur_bank, reg_ptr[9:0], 1'b0, ev.rx_byte, '0, '0, '0, 1'b0);
          end
          step_pointer();
        end else begin
          report_done(1'b1);
          open_transaction(ev);
        end
      end
      PH_TX: begin
        if (ev.req_type == REQ_TX) begin
          transmit_byte(ev.read_data);
        end else begin
          report_done(1'b0);
          open_transaction(ev);
        end
      end
      default: begin
        open_transaction(ev);
      end
    endcase
    staged_replies[staged_replies.size() - 1].last = 1'b1;
    while (staged_replies.size() != 0) expected_replies.push_back(staged_replies.pop_front());
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_bus_event(offered_event);
        events_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_event = pending_events.pop_front();
          in_valid_i      <= 1'b1;
          req_type_i      <= offered_event.req_type;
          rx_byte_i       <= offered_event.rx_byte;
          store_accepts_i <= offered_event.store_accepts;
          read_data_i     <= offered_event.read_data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      out_ready_i  <= 1'b0;
      hold_left    <= PRESSURE_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic void compare_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual kind %0d", $time, result_kind_o);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        compare_field("result_kind", want.kind, result_kind_o);
        compare_field("bank_number", want.bank_number, bank_number_o);
        compare_field("offset", want.offset, offset_o);
        compare_field("write_strobe", want.write_strobe, write_strobe_o);
        compare_field("data_byte", want.data_byte, data_byte_o);
        compare_field("device_address", want.device_address, device_address_o);
        compare_field("start_address", want.start_address, start_address_o);
        compare_field("byte_count", want.byte_count, byte_count_o);
        compare_field("is_write", want.is_write, is_write_o);
        compare_field("last", want.last, last_o);
      end
      replies_checked++;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BANK_MASK: bank_mask = value;
      CFG_DEFAULT_BANK: cur_bank = value[5:0];
      CFG_EVENT_ENABLE: report_en = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [63:0] mask, logic [5:0] dbank, logic en);
    write_cfg(CFG_BANK_MASK, mask);
    write_cfg(CFG_DEFAULT_BANK, 64'(dbank));
    write_cfg(CFG_EVENT_ENABLE, 64'(en));
    settings_applied++;
  endtask

  task automatic queue_event(logic [2:0] t, logic [7:0] rx, logic acc, logic [7:0] rd);
    item_t ev;
    ev.req_type      = t;
    ev.rx_byte       = rx;
    ev.store_accepts = acc;
    ev.read_data     = rd;
    pending_events.push_back(ev);
    events_issued++;
  endtask

  task automatic drain();
    while (events_accepted != events_issued || expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_bank();
    logic [5:0] b;
    b = 6'($urandom);
    if (bank_mask != '0 && $urandom_range(3) != 0) begin
      while (!bank_mask[b]) b = 6'($urandom);
    end
    return b;
  endfunction

  // Mostly well-formed write and read transactions, some with a repeated
  // start or a broken address, mixed with random bus noise.
  task automatic queue_transactions(int unsigned target);
    int unsigned first_issued;
    int unsigned pick;
    int unsigned beats;
    logic [7:0]  hi;
    logic [7:0]  lo;
    first_issued = events_issued;
    while (events_issued - first_issued < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        queue_event(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        if (pick < 55) begin
          queue_event(REQ_ADDR_WR, 8'($urandom), 1'($urandom), 8'($urandom));
          hi = {pick_bank(), 2'($urandom)};
          lo = 8'($urandom);
          if ($urandom_range(4) == 0) begin
            hi[1:0] = 2'b11;
            lo      = 8'($urandom_range(255, 250));
          end
          queue_event(REQ_DATA, hi, 1'($urandom), 8'($urandom));
          if ($urandom_range(9) != 0) begin
            queue_event(REQ_DATA, lo, 1'($urandom), 8'($urandom));
            beats = $urandom_range(6);
            repeat (beats) begin
              queue_event(REQ_DATA, 8'($urandom), 1'($urandom_range(3) != 0), 8'($urandom));
            end
          end
        end
        if (pick >= 55 || $urandom_range(2) == 0) begin
          queue_event(REQ_ADDR_RD, 8'($urandom), 1'($urandom), 8'($urandom));
          beats = $urandom_range(6);
          repeat (beats) queue_event(REQ_TX, 8'($urandom), 1'($urandom), 8'($urandom));
        end
        if ($urandom_range(9) < 7) begin
          queue_event(3'($urandom_range(REQ_OTHER, REQ_UNKNOWN_HI)), 8'($urandom),
                      1'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    int unsigned seg;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct   = 13;
    receiver_idle_pct = 78;
    apply_settings(64'h8000_0000_0000_0001, 6'd63, 1'b1);

    // Stray events while idle, including unknown request types.
    queue_event(REQ_TX, 8'hff, 1'b1, 8'hff);
    queue_event(REQ_UNKNOWN_LO, 8'h00, 1'b0, 8'h00);
    queue_event(REQ_UNKNOWN_HI, 8'hff, 1'b1, 8'hff);
    queue_event(REQ_OTHER, 8'h00, 1'b0, 8'h00);
    // Read from the default bank before any address is written.
    queue_event(REQ_ADDR_RD, 8'hff, 1'b0, 8'hff);
    queue_event(REQ_TX, 8'h00, 1'b1, 8'h00);
    queue_event(REQ_OTHER, 8'hff, 1'b1, 8'hff);
    // Address bytes arriving in both address phases restart the transfer.
    queue_event(REQ_ADDR_WR, 8'h00, 1'b1, 8'h00);
    queue_event(REQ_ADDR_WR, 8'h00, 1'b1, 8'h00);
    queue_event(REQ_DATA, 8'h03, 1'b1, 8'h00);
    queue_event(REQ_ADDR_WR, 8'h00, 1'b1, 8'h00);
    queue_event(REQ_DATA, 8'h03, 1'b1, 8'h00);
    queue_event(REQ_DATA, 8'hff, 1'b1, 8'h00);
    // Writes at the top of bank 0, a refused byte, and the offset wrap.
    queue_event(REQ_DATA, 8'hff, 1'b1, 8'hff);
    queue_event(REQ_DATA, 8'h00, 1'b0, 8'h00);
    queue_event(REQ_DATA, 8'ha5, 1'b1, 8'h00);
    // Breaks during a write and during a read.
    queue_event(REQ_ADDR_RD, 8'h81, 1'b0, 8'h5a);
    queue_event(REQ_ADDR_WR, 8'h42, 1'b0, 8'h00);
    // An absent bank: writes are refused and reads return zero.
    queue_event(REQ_DATA, 8'h04, 1'b1, 8'h00);
    queue_event(REQ_DATA, 8'h00, 1'b1, 8'h00);
    queue_event(REQ_DATA, 8'hff, 1'b1, 8'hff);
    queue_event(REQ_ADDR_RD, 8'hfe, 1'b1, 8'hff);
    queue_event(REQ_DATA, 8'h11, 1'b1, 8'h22);
    drain();

    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        sender_idle_pct   = 78;
        receiver_idle_pct = 13;
      end
      if (seg == 4) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case (seg)
        0: apply_settings('1, 6'd0, 1'b1);
        1: apply_settings('0, 6'd63, 1'b0);
        2: apply_settings({$urandom, $urandom}, 6'($urandom), 1'b1);
        3: apply_settings({$urandom, $urandom}, 6'($urandom), 1'b0);
        4: apply_settings({$urandom, $urandom}, 6'($urandom), 1'b1);
        default: apply_settings('1, 6'd63, 1'b1);
      endcase
      queue_transactions(SEGMENT_EVENTS);
      if (seg == 4) holds_requested++;
      drain();
    end

    $display("Run covered %0d bus events and %0d checked replies over %0d register settings,",
             events_accepted, replies_checked, settings_applied);
    $display("with idle gaps on both sides and a long receiver stall under a full input.");
    if (mismatch_count == 0) begin
      $display("** i2c_target_register_access_fsm_core: PASSED **");
    end else begin
      $display("** i2c_target_register_access_fsm_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout with %0d replies outstanding", $time, expected_replies.size());
    $display("** i2c_target_register_access_fsm_core: FAILED **");
    $finish;
  end

endmodule

/* files.f */
rtl/core/i2cra_pkg.sv
rtl/core/i2cra_step.sv
rtl/core/i2cra_out_stage.sv
rtl/core/i2c_target_register_access_fsm_core.sv
rtl/core/i2cra_checker.sv
bench/i2c_target_register_access_fsm_core_tb.sv
